// ===== src/uiu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uiu_pkg: shared types and constants of the user interrupt unit
// Command and fault codes, register indexes, word structs and masks.
// ----------------------------------------------------------------------------
package uiu_pkg;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned DataWidth     = 64;

   typedef enum logic [2:0] {
      CMD_NOTIFY   = 3'd0,
      CMD_STUI     = 3'd1,
      CMD_CLUI     = 3'd2,
      CMD_TESTUI   = 3'd3,
      CMD_DELIVER  = 3'd4,
      CMD_UIRET    = 3'd5,
      CMD_SENDUIPI = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      FAULT_NONE      = 2'd0,
      FAULT_UD        = 2'd1,
      FAULT_GP        = 2'd2,
      FAULT_NOTHING   = 2'd3
   } fault_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_FEATURE_ENABLE   = 3'd0,
      CSR_SEND_ENABLE      = 3'd1,
      CSR_TABLE_BASE       = 3'd2,
      CSR_TABLE_LAST_INDEX = 3'd3,
      CSR_HANDLER_ADDRESS  = 3'd4,
      CSR_STACK_OFFSET     = 3'd5
   } csr_index_type;

   localparam logic [63:0] StackAlignMask = 64'hffff_ffff_ffff_fff0;
   localparam logic [63:0] EntryRsvdMask  = 64'hffff_ffff_ffff_00fe;
   localparam logic [63:0] DescRsvdMask   = 64'h0000_0000_ff00_fffc;
   localparam logic [63:0] DescAlignMask  = 64'h0000_0000_0000_003f;
   localparam logic [63:0] TableBaseMask  = 64'hffff_ffff_ffff_fff0;

   typedef struct packed {
      logic        feature_enable;
      logic        send_enable;
      logic [63:0] table_base;
      logic [31:0] table_last_index;
      logic [63:0] handler_address;
      logic [63:0] stack_offset;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  command;
      logic        user_long_mode;
      logic [63:0] operand_value;
      logic [63:0] entry_low_word;
      logic [63:0] descriptor_address;
      logic [63:0] descriptor_low_word;
      logic [63:0] descriptor_high_word;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  fault;
      logic        flag_value;
      logic [5:0]  vector;
      logic [63:0] new_stack_pointer;
      logic [63:0] entry_address;
      logic [63:0] new_descriptor_low;
      logic [63:0] new_descriptor_high;
      logic        notify;
      logic [7:0]  notify_vector;
      logic [31:0] notify_destination;
      logic        pending;
      logic        deliverable;
   } rsp_word_type;

   // bits 63:47 all equal
   function automatic logic is_canonical(input logic [63:0] addr);
      is_canonical = (&addr[63:47]) || (~|addr[63:47]);
   endfunction

   // index of the highest set bit, zero for an empty word
   function automatic logic [5:0] highest_bit(input logic [63:0] bits);
      logic [5:0] idx;
      idx = '0;
      for (int i = 0; i < 64; i++) begin
         if (bits[i]) begin
            idx = 6'(i);
         end
      end
      highest_bit = idx;
   endfunction

endpackage

// ===== src/uiu_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uiu_req_if: command channel
// Valid/ready channel carrying one command word.
// ----------------------------------------------------------------------------
interface uiu_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  command;
   logic        user_long_mode;
   logic [63:0] operand_value;
   logic [63:0] entry_low_word;
   logic [63:0] descriptor_address;
   logic [63:0] descriptor_low_word;
   logic [63:0] descriptor_high_word;

   modport source (
      output valid, command, user_long_mode, operand_value, entry_low_word,
             descriptor_address, descriptor_low_word, descriptor_high_word,
      input  ready
   );
   modport sink (
      input  valid, command, user_long_mode, operand_value, entry_low_word,
             descriptor_address, descriptor_low_word, descriptor_high_word,
      output ready
   );
endinterface

// ===== src/uiu_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uiu_rsp_if: result channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface uiu_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  fault;
   logic        flag_value;
   logic [5:0]  vector;
   logic [63:0] new_stack_pointer;
   logic [63:0] entry_address;
   logic [63:0] new_descriptor_low;
   logic [63:0] new_descriptor_high;
   logic        notify;
   logic [7:0]  notify_vector;
   logic [31:0] notify_destination;
   logic        pending;
   logic        deliverable;

   modport source (
      output valid, fault, flag_value, vector, new_stack_pointer, entry_address,
             new_descriptor_low, new_descriptor_high, notify, notify_vector,
             notify_destination, pending, deliverable,
      input  ready
   );
   modport sink (
      input  valid, fault, flag_value, vector, new_stack_pointer, entry_address,
             new_descriptor_low, new_descriptor_high, notify, notify_vector,
             notify_destination, pending, deliverable,
      output ready
   );
endinterface

// ===== src/uiu_csr_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uiu_csr_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface uiu_csr_if;
   logic                                valid;
   logic                                ready;
   logic [uiu_pkg::CsrIndexWidth-1:0]   reg_index;
   logic [uiu_pkg::DataWidth-1:0]       write_data;

   modport source (output valid, reg_index, write_data, input ready);
   modport sink   (input valid, reg_index, write_data, output ready);
endinterface

// ===== src/user_interrupt_unit_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// user_interrupt_unit_top: user interrupt unit
// Holds the pending request bits and the user interrupt flag, runs one
// command per word and returns one result word per command.
//
//   channel   dir   handshake      word
//   req_if    in    valid/ready    command and operands
//   rsp_if    out   valid/ready    fault, flag, delivery and send results
//   csr_if    in    valid/ready    register index and write data
//
// One command per cycle while results are taken; an accepted command is held in
// the input register, then its result word in the result register.
// Request bits and flag are updated at the edge the result is registered,
// so the next command in the input register already sees them.
// A stalled result holds; the input register accepts while it is empty or
// while the result register is free or being drained. Reset clears state and
// settings.
// ----------------------------------------------------------------------------
module user_interrupt_unit_top (
   input  logic       clock,
   input  logic       reset,
   uiu_req_if.sink    req_if,
   uiu_rsp_if.source  rsp_if,
   uiu_csr_if.sink    csr_if
);

   uiu_pkg::cfg_type      cfg;
   uiu_pkg::req_word_type req_word;
   uiu_pkg::req_word_type s1_word_ff;
   uiu_pkg::rsp_word_type exec_result;
   uiu_pkg::rsp_word_type rsp_word_ff;

   logic        s1_vld_ff;
   logic        s1_vld_in;
   logic        rsp_vld_ff;
   logic        rsp_vld_in;
   logic [63:0] bits_ff;
   logic [63:0] bits_in;
   logic        flag_ff;
   logic        flag_in;
   logic [63:0] bits_nxt;
   logic        flag_nxt;
   logic        out_free;
   logic        advance;
   logic        req_fire;

   uiu_cfg_regs u_cfg_regs (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   uiu_exec u_exec (
      .cfg      (cfg),
      .word     (s1_word_ff),
      .bits_cur (bits_ff),
      .flag_cur (flag_ff),
      .result   (exec_result),
      .bits_nxt (bits_nxt),
      .flag_nxt (flag_nxt)
   );

   assign req_word.command              = req_if.command;
   assign req_word.user_long_mode       = req_if.user_long_mode;
   assign req_word.operand_value        = req_if.operand_value;
   assign req_word.entry_low_word       = req_if.entry_low_word;
   assign req_word.descriptor_address   = req_if.descriptor_address;
   assign req_word.descriptor_low_word  = req_if.descriptor_low_word;
   assign req_word.descriptor_high_word = req_if.descriptor_high_word;

   assign out_free     = !rsp_vld_ff || rsp_if.ready;
   assign advance      = s1_vld_ff && out_free;
   assign req_if.ready = !s1_vld_ff || out_free;
   assign req_fire     = req_if.valid && req_if.ready;

   always_comb begin
      s1_vld_in  = req_if.ready ? req_if.valid : s1_vld_ff;
      rsp_vld_in = out_free ? advance : rsp_vld_ff;
      bits_in    = advance ? bits_nxt : bits_ff;
      flag_in    = advance ? flag_nxt : flag_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         bits_ff    <= '0;
         flag_ff    <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         bits_ff    <= bits_in;
         flag_ff    <= flag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_word_ff <= req_word;
      end
      if (advance) begin
         rsp_word_ff <= exec_result;
      end
   end

   assign rsp_if.valid               = rsp_vld_ff;
   assign rsp_if.fault               = rsp_word_ff.fault;
   assign rsp_if.flag_value          = rsp_word_ff.flag_value;
   assign rsp_if.vector              = rsp_word_ff.vector;
   assign rsp_if.new_stack_pointer   = rsp_word_ff.new_stack_pointer;
   assign rsp_if.entry_address       = rsp_word_ff.entry_address;
   assign rsp_if.new_descriptor_low  = rsp_word_ff.new_descriptor_low;
   assign rsp_if.new_descriptor_high = rsp_word_ff.new_descriptor_high;
   assign rsp_if.notify              = rsp_word_ff.notify;
   assign rsp_if.notify_vector       = rsp_word_ff.notify_vector;
   assign rsp_if.notify_destination  = rsp_word_ff.notify_destination;
   assign rsp_if.pending             = rsp_word_ff.pending;
   assign rsp_if.deliverable         = rsp_word_ff.deliverable;

endmodule

// ===== src/uiu_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uiu_cfg_regs: configuration registers
// Takes register writes from the csr channel and holds the settings.
// ----------------------------------------------------------------------------
module uiu_cfg_regs (
   input  logic              clock,
   input  logic              reset,
   uiu_csr_if.sink           csr_if,
   output uiu_pkg::cfg_type  cfg
);

   uiu_pkg::cfg_type cfg_ff;
   uiu_pkg::cfg_type cfg_in;
   logic             wr_en;

   assign csr_if.ready = 1'b1;
   assign wr_en        = csr_if.valid;
   assign cfg          = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (uiu_pkg::csr_index_type'(csr_if.reg_index))
            uiu_pkg::CSR_FEATURE_ENABLE:   cfg_in.feature_enable   = csr_if.write_data[0];
            uiu_pkg::CSR_SEND_ENABLE:      cfg_in.send_enable      = csr_if.write_data[0];
            uiu_pkg::CSR_TABLE_BASE:       cfg_in.table_base       = csr_if.write_data;
            uiu_pkg::CSR_TABLE_LAST_INDEX: cfg_in.table_last_index = csr_if.write_data[31:0];
            uiu_pkg::CSR_HANDLER_ADDRESS:  cfg_in.handler_address  = csr_if.write_data;
            uiu_pkg::CSR_STACK_OFFSET:     cfg_in.stack_offset     = csr_if.write_data;
            default: begin
               // unused indexes are dropped
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== src/uiu_exec.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uiu_exec: command execution logic
// Decodes one command word against the current request bits and flag, and
// gives the result word and the next state.
// ----------------------------------------------------------------------------
module uiu_exec (
   input  uiu_pkg::cfg_type      cfg,
   input  uiu_pkg::req_word_type word,
   input  logic [63:0]           bits_cur,
   input  logic                  flag_cur,
   output uiu_pkg::rsp_word_type result,
   output logic [63:0]           bits_nxt,
   output logic                  flag_nxt
);

   logic [5:0]  top_vec;
   logic [63:0] stack_raw;
   logic [7:0]  user_vec;
   logic        entry_bad;
   logic        notify_now;
   logic        pending_nxt;

   assign top_vec   = uiu_pkg::highest_bit(bits_cur);
   assign stack_raw = cfg.stack_offset[0] ? cfg.stack_offset
                                          : word.operand_value - cfg.stack_offset;
   assign user_vec  = word.entry_low_word[15:8];
   assign entry_bad = !word.entry_low_word[0]
                   || ((word.entry_low_word & uiu_pkg::EntryRsvdMask) != '0)
                   || (user_vec[7:6] != 2'b00)
                   || ((word.descriptor_address & uiu_pkg::DescAlignMask) != '0)
                   || ((word.descriptor_low_word & uiu_pkg::DescRsvdMask) != '0);
   // neither outstanding nor suppressed
   assign notify_now = (word.descriptor_low_word[1:0] == 2'b00);

   always_comb begin
      result   = '0;
      bits_nxt = bits_cur;
      flag_nxt = flag_cur;

      if (!cfg.feature_enable && (word.command <= uiu_pkg::CMD_SENDUIPI)) begin
         result.fault = uiu_pkg::FAULT_UD;
      end else begin
         case (uiu_pkg::cmd_type'(word.command))
            uiu_pkg::CMD_NOTIFY: begin
               bits_nxt = bits_cur | word.operand_value;
            end
            uiu_pkg::CMD_STUI: begin
               flag_nxt = 1'b1;
            end
            uiu_pkg::CMD_CLUI: begin
               flag_nxt = 1'b0;
            end
            uiu_pkg::CMD_TESTUI: begin
               flag_nxt = flag_cur;
            end
            uiu_pkg::CMD_DELIVER: begin
               if (!word.user_long_mode || !flag_cur || (bits_cur == '0)) begin
                  result.fault = uiu_pkg::FAULT_NOTHING;
               end else if (!uiu_pkg::is_canonical(cfg.handler_address)) begin
                  result.fault = uiu_pkg::FAULT_GP;
               end else begin
                  result.vector            = top_vec;
                  result.new_stack_pointer = stack_raw & uiu_pkg::StackAlignMask;
                  bits_nxt                 = bits_cur & ~(64'd1 << top_vec);
                  flag_nxt                 = 1'b0;
               end
            end
            uiu_pkg::CMD_UIRET: begin
               if (!uiu_pkg::is_canonical(word.operand_value)) begin
                  result.fault = uiu_pkg::FAULT_GP;
               end else begin
                  flag_nxt = 1'b1;
               end
            end
            uiu_pkg::CMD_SENDUIPI: begin
               if (!cfg.send_enable) begin
                  result.fault = uiu_pkg::FAULT_UD;
               end else if (word.operand_value > {32'd0, cfg.table_last_index}) begin
                  result.fault = uiu_pkg::FAULT_GP;
               end else begin
                  result.entry_address = (cfg.table_base & uiu_pkg::TableBaseMask)
                                       + {word.operand_value[59:0], 4'b0000};
                  if (entry_bad) begin
                     result.fault = uiu_pkg::FAULT_GP;
                  end else begin
                     result.new_descriptor_low  = {word.descriptor_low_word[63:1],
                                                   word.descriptor_low_word[0] | notify_now};
                     result.new_descriptor_high = word.descriptor_high_word
                                                | (64'd1 << user_vec[5:0]);
                     result.notify              = notify_now;
                     if (notify_now) begin
                        result.notify_vector      = word.descriptor_low_word[23:16];
                        result.notify_destination = word.descriptor_low_word[63:32];
                     end
                  end
               end
            end
            default: begin
               // unused code: no effect
               bits_nxt = bits_cur;
            end
         endcase
      end

      pending_nxt        = cfg.feature_enable && (bits_nxt != '0);
      result.flag_value  = flag_nxt;
      result.pending     = pending_nxt;
      result.deliverable = pending_nxt && word.user_long_mode && flag_nxt;
   end

endmodule
